[hw/rtl/ttb_pkg.sv]
package ttb_pkg;

   // command codes
   localparam logic [2:0] CMD_TICK         = 3'd0;
   localparam logic [2:0] CMD_ARM_PERIODIC = 3'd1;
   localparam logic [2:0] CMD_ARM_ONESHOT  = 3'd2;
   localparam logic [2:0] CMD_CANCEL       = 3'd3;
   localparam logic [2:0] CMD_STOP         = 3'd4;
   localparam logic [2:0] CMD_SET_FREQ     = 3'd5;

   localparam logic [31:0] FREQ_FLOOR    = 32'd18;
   localparam logic [31:0] CLK_BASE_HZ   = 32'd1193182;
   localparam logic [21:0] CLK_TRIPLE_HZ = 22'd3579546;
   localparam logic [20:0] HALF_TRIPLE   = 21'd1789773;
   localparam logic [31:0] DELTA_SCALE   = 32'd3685982306;
   localparam logic [15:0] COUNT_MAX     = 16'hffff;
   localparam logic [37:0] DELTA_RESET   = 38'd4297912962;
   // ceil(2^19/3) and ceil(2^17/3): exact division by 3 below 2^19 and 2^17
   localparam logic [17:0] RECIP3_19     = 18'd174763;
   localparam logic [17:0] RECIP3_17     = 18'd43691;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] interval_ms;
      logic [31:0] frequency_hz;
   } req_type;

   typedef struct packed {
      logic        fire;
      logic [31:0] time_ms;
      logic [51:0] time_us;
      logic [15:0] divisor;
      logic        divisor_written;
   } rsp_type;

   // shared arithmetic unit operands and results
   typedef struct packed {
      logic [63:0] add_a;
      logic [63:0] add_b;
      logic        sub;
      logic [31:0] mul_a;
      logic [17:0] mul_b;
   } alu_op_type;

   typedef struct packed {
      logic [63:0] sum;
      logic        carry;
      logic [49:0] product;
   } alu_res_type;

endpackage

[hw/rtl/ttb_chan_if.sv]
interface ttb_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/ttb_alu.sv]
module ttb_alu (
   input  ttb_pkg::alu_op_type  op,
   output ttb_pkg::alu_res_type res
);
   import ttb_pkg::*;

   logic [64:0] wide;

   // a + b, or a - b as a + ~b + 1; carry set means a >= b on subtract
   assign wide = {1'b0, op.add_a} + {1'b0, op.add_b ^ {64{op.sub}}} + {64'b0, op.sub};
   assign res.sum     = wide[63:0];
   assign res.carry   = wide[64];
   assign res.product = {18'b0, op.mul_a} * {32'b0, op.mul_b};
endmodule

[hw/rtl/tick_time_base_event_timer.sv]
// Tick time base with one event timer. The block holds a 32.32 fixed-point
// millisecond time base and one timer, and takes one command item at a time on
// req_if; each command gives exactly one result item on rsp_if with the time in
// ms and us. A tick adds the per-tick delta and may fire the timer; a periodic
// timer reloads its deadline by one period (no drift), a one-shot disarms.
// Stop writes divisor 0 and masks ticks until the next arm; set frequency works
// out the 16-bit counter divisor and the new delta. All arithmetic runs through
// one shared 64-bit add/subtract unit and one 32x18 multiplier under a small
// sequencer, and req_if.ready is low while an item is being worked on. Set
// frequency runs the 22-step restoring division of the 3.58 MHz constant,
// except at the clamped ends of the range. A new item is taken the cycle
// after the result is registered, even if that result has not yet been taken.
module tick_time_base_event_timer (
   input logic        clock,
   input logic        reset,
   ttb_chan_if.sink   req_if,
   ttb_chan_if.source rsp_if
);
   import ttb_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_TICK_ADD = 4'd1;
   localparam logic [3:0] S_TICK_CMP = 4'd2;
   localparam logic [3:0] S_RELOAD   = 4'd3;
   localparam logic [3:0] S_ARM      = 4'd4;
   localparam logic [3:0] S_DIV      = 4'd5;
   localparam logic [3:0] S_DIV3     = 4'd6;
   localparam logic [3:0] S_MOD3     = 4'd7;
   localparam logic [3:0] S_ROUND    = 4'd8;
   localparam logic [3:0] S_DELTA    = 4'd9;
   localparam logic [3:0] S_US_A     = 4'd10;
   localparam logic [3:0] S_US_B     = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] ival_ff, ival_in;
   logic [31:0] freq_ff, freq_in;

   // architectural state
   logic [63:0] time_base_ff, time_base_in;
   logic [37:0] tick_delta_ff, tick_delta_in;
   logic [63:0] deadline_ff, deadline_in;
   logic [63:0] period_ff, period_in;
   logic        handler_set_ff, handler_set_in;
   logic        ticks_enabled_ff, ticks_enabled_in;

   // per-item working registers
   logic        fire_ff, fire_in;
   logic        div_wr_ff, div_wr_in;
   logic [15:0] divisor_ff, divisor_in;
   logic [21:0] quot_ff, quot_in;
   logic [20:0] rem_ff, rem_in;
   logic [4:0]  bit_idx_ff, bit_idx_in;
   logic [15:0] count_ff, count_in;
   logic [63:0] scratch_ff, scratch_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   alu_op_type  alu_op;
   alu_res_type alu_res;

   logic        req_take;
   logic [21:0] rem_shift;
   logic [21:0] count_round;
   logic [41:0] time_hi;

   ttb_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign req_if.ready   = (state_ff == S_IDLE);
   assign req_take       = req_if.valid && (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   // next partial remainder: shift in the next dividend bit, MSB first
   assign rem_shift   = {rem_ff, CLK_TRIPLE_HZ[bit_idx_ff]};
   // divided count plus its rounding bit (remainder at least half the dividend)
   assign count_round = quot_ff + {21'b0, (rem_ff >= HALF_TRIPLE)};
   // ms in 32.10 fixed point, the base of the us figure
   assign time_hi     = time_base_ff[63:22];

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      ival_in          = ival_ff;
      freq_in          = freq_ff;
      time_base_in     = time_base_ff;
      tick_delta_in    = tick_delta_ff;
      deadline_in      = deadline_ff;
      period_in        = period_ff;
      handler_set_in   = handler_set_ff;
      ticks_enabled_in = ticks_enabled_ff;
      fire_in          = fire_ff;
      div_wr_in        = div_wr_ff;
      divisor_in       = divisor_ff;
      quot_in          = quot_ff;
      rem_in           = rem_ff;
      bit_idx_in       = bit_idx_ff;
      count_in         = count_ff;
      scratch_in       = scratch_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_payload_in   = rsp_payload_ff;
      alu_op           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in     = req_if.payload.cmd;
               ival_in    = req_if.payload.interval_ms;
               freq_in    = req_if.payload.frequency_hz;
               fire_in    = 1'b0;
               div_wr_in  = 1'b0;
               divisor_in = '0;
               unique case (req_if.payload.cmd) inside
                  CMD_TICK: begin
                     state_in = S_TICK_ADD;
                  end
                  CMD_ARM_PERIODIC, CMD_ARM_ONESHOT: begin
                     state_in = S_ARM;
                  end
                  CMD_CANCEL: begin
                     deadline_in = '0;
                     state_in    = S_US_A;
                  end
                  CMD_STOP: begin
                     deadline_in      = '0;
                     period_in        = '0;
                     ticks_enabled_in = 1'b0;
                     div_wr_in        = 1'b1;
                     state_in         = S_US_A;
                  end
                  CMD_SET_FREQ: begin
                     rem_in     = '0;
                     quot_in    = '0;
                     bit_idx_in = 5'd21;
                     if (req_if.payload.frequency_hz <= FREQ_FLOOR) begin
                        count_in = COUNT_MAX;
                        state_in = S_DELTA;
                     end else if (req_if.payload.frequency_hz >= CLK_BASE_HZ) begin
                        count_in = 16'd1;
                        state_in = S_DELTA;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     state_in = S_US_A;
                  end
               endcase
            end
         end
         S_TICK_ADD: begin
            state_in = S_US_A;
            if (ticks_enabled_ff) begin
               alu_op.add_a = time_base_ff;
               alu_op.add_b = {26'b0, tick_delta_ff};
               time_base_in = alu_res.sum;
               if (handler_set_ff && (deadline_ff != '0))
                  state_in = S_TICK_CMP;
            end
         end
         S_TICK_CMP: begin
            alu_op.add_a = time_base_ff;
            alu_op.add_b = deadline_ff;
            alu_op.sub   = 1'b1;
            state_in     = S_US_A;
            if (alu_res.carry) begin
               fire_in = 1'b1;
               if (period_ff != '0)
                  state_in = S_RELOAD;
               else
                  deadline_in = '0;
            end
         end
         S_RELOAD: begin
            // move on by exactly one period; a wrap to zero reads as disarmed
            alu_op.add_a = deadline_ff;
            alu_op.add_b = period_ff;
            deadline_in  = alu_res.sum;
            state_in     = S_US_A;
         end
         S_ARM: begin
            alu_op.add_a     = time_base_ff;
            alu_op.add_b     = {ival_ff, 32'b0};
            deadline_in      = alu_res.sum;
            period_in        = (cmd_ff == CMD_ARM_PERIODIC) ? {ival_ff, 32'b0} : 64'b0;
            handler_set_in   = 1'b1;
            ticks_enabled_in = 1'b1;
            state_in         = S_US_A;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            alu_op.add_a = {42'b0, rem_shift};
            alu_op.add_b = {43'b0, freq_ff[20:0]};
            alu_op.sub   = 1'b1;
            rem_in       = alu_res.carry ? alu_res.sum[20:0] : rem_shift[20:0];
            quot_in      = {quot_ff[20:0], alu_res.carry};
            bit_idx_in   = bit_idx_ff - 5'd1;
            if (bit_idx_ff == 5'd0)
               state_in = S_DIV3;
         end
         S_DIV3: begin
            alu_op.mul_a = {10'b0, count_round};
            alu_op.mul_b = RECIP3_19;
            count_in     = alu_res.product[34:19];
            state_in     = S_MOD3;
         end
         S_MOD3: begin
            alu_op.mul_a = {16'b0, count_ff};
            alu_op.mul_b = RECIP3_17;
            scratch_in   = {48'b0, alu_res.product[32:17]};
            state_in     = S_ROUND;
         end
         S_ROUND: begin
            // 3 * (count / 3); a mismatch means a non-zero remainder
            alu_op.add_a = scratch_ff;
            alu_op.add_b = {scratch_ff[62:0], 1'b0};
            count_in     = count_ff + {15'b0, (alu_res.sum[15:0] != count_ff)};
            state_in     = S_DELTA;
         end
         S_DELTA: begin
            alu_op.mul_a  = DELTA_SCALE;
            alu_op.mul_b  = {2'b0, count_ff};
            tick_delta_in = alu_res.product[47:10];
            divisor_in    = count_ff;
            div_wr_in     = 1'b1;
            state_in      = S_US_A;
         end
         S_US_A: begin
            // x * 1000 / 1024 = x * 125 / 128; first 128x - 4x
            alu_op.add_a = {15'b0, time_hi, 7'b0};
            alu_op.add_b = {20'b0, time_hi, 2'b0};
            alu_op.sub   = 1'b1;
            scratch_in   = alu_res.sum;
            state_in     = S_US_B;
         end
         S_US_B: begin
            // then + x
            alu_op.add_a = scratch_ff;
            alu_op.add_b = {22'b0, time_hi};
            scratch_in   = alu_res.sum;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.fire            = fire_ff;
               rsp_payload_in.time_ms         = time_base_ff[63:32];
               rsp_payload_in.time_us         = {10'b0, scratch_ff[48:7]};
               rsp_payload_in.divisor         = divisor_ff;
               rsp_payload_in.divisor_written = div_wr_ff;
               state_in                       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         time_base_ff     <= '0;
         tick_delta_ff    <= DELTA_RESET;
         deadline_ff      <= '0;
         period_ff        <= '0;
         handler_set_ff   <= 1'b0;
         ticks_enabled_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         time_base_ff     <= time_base_in;
         tick_delta_ff    <= tick_delta_in;
         deadline_ff      <= deadline_in;
         period_ff        <= period_in;
         handler_set_ff   <= handler_set_in;
         ticks_enabled_ff <= ticks_enabled_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      ival_ff        <= ival_in;
      freq_ff        <= freq_in;
      fire_ff        <= fire_in;
      div_wr_ff      <= div_wr_in;
      divisor_ff     <= divisor_in;
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      bit_idx_ff     <= bit_idx_in;
      count_ff       <= count_in;
      scratch_ff     <= scratch_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef SYNTHESIS
   // a firing item never also writes the divisor
   a_fire_not_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.fire |-> !rsp_payload_ff.divisor_written)
      else $error("fire and divisor_written together");

   // divisor is zero unless written
   a_divisor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.divisor_written |-> rsp_payload_ff.divisor == '0)
      else $error("divisor non-zero without a write");

   // stop masks ticks and disarms at once
   a_stop_masks: assert property (@(posedge clock) disable iff (reset)
      req_take && req_if.payload.cmd == CMD_STOP |=> !ticks_enabled_ff && deadline_ff == '0)
      else $error("stop did not mask ticks");

   // time base moves only in the tick add step
   a_time_base_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_TICK_ADD |=> $stable(time_base_ff))
      else $error("time base changed outside a tick");
`endif
endmodule
